### sv/siel_pkg.sv
package siel_pkg;

  // table geometry and limits
  localparam int DEF_NUM_LOCKS  = 64;
  localparam int MAX_READERS    = 65535;
  localparam int MAX_RECURSION  = 255;
  localparam int NUM_REQUESTERS = 256;

  // field widths
  localparam int FUNC_W  = 3;
  localparam int INDEX_W = 6;
  localparam int KIND_W  = 2;
  localparam int SEQ_W   = 32;
  localparam int ID_W    = 8;
  localparam int RDR_W   = 16;
  localparam int REC_W   = 8;
  localparam int WAKE_W  = 2;

  // saturation points of the counters
  localparam int READER_CAP_I  = (MAX_READERS < 65535) ? MAX_READERS : 65535;
  localparam int RECURSE_CAP_I = (MAX_RECURSION < 255) ? MAX_RECURSION : 255;
  localparam logic [RDR_W-1:0] READER_CAP  = RDR_W'(READER_CAP_I);
  localparam logic [REC_W-1:0] RECURSE_CAP = REC_W'(RECURSE_CAP_I);

  // request operations
  localparam logic [FUNC_W-1:0] FN_TRYLOCK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RELOCK    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WAIT      = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNLOCK    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_UPGRADE   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DOWNGRADE = 3'd5;
  localparam logic [FUNC_W-1:0] FN_INCREMENT = 3'd6;

  // lock modes
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;

  // waiter bit positions
  localparam int WAIT_READ   = 0;
  localparam int WAIT_INTENT = 1;
  localparam int WAIT_WRITE  = 2;

  // wake classes
  localparam logic [WAKE_W-1:0] WAKE_NONE    = 2'd0;
  localparam logic [WAKE_W-1:0] WAKE_READERS = 2'd1;
  localparam logic [WAKE_W-1:0] WAKE_INTENT  = 2'd2;
  localparam logic [WAKE_W-1:0] WAKE_WRITER  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] lock_index;
    logic [KIND_W-1:0]  lock_kind;
    logic [SEQ_W-1:0]   seq_tag;
    logic [ID_W-1:0]    requester_id;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic               request_error;
    logic [WAKE_W-1:0]  wake_class;
    logic [ID_W-1:0]    wake_target;
    logic [SEQ_W-1:0]   seq_now;
    logic [RDR_W-1:0]   readers_now;
    logic               intent_now;
  } rsp_t;

  // one lock entry of the table
  typedef struct packed {
    logic [RDR_W-1:0] readers;
    logic             intent;
    logic [SEQ_W-1:0] seq;
    logic [2:0]       waiters;
    logic [REC_W-1:0] recursion;
    logic [ID_W-1:0]  owner;
  } entry_t;

  // update result handed to the sequencer
  typedef struct packed {
    logic we;
    rsp_t res;
  } upd_t;

endpackage

### sv/siel_chan_if.sv
interface siel_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input ready, input data);
endinterface

### sv/siel_mem.sv
module siel_mem
  import siel_pkg::*;
#(
  parameter int DEPTH  = DEF_NUM_LOCKS,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/siel_update.sv
module siel_update
  import siel_pkg::*;
#(
  parameter int NUM_LOCKS = DEF_NUM_LOCKS
) (
  input  req_t   req,
  input  entry_t cur,
  output entry_t nxt,
  output upd_t   upd
);

  entry_t            n;
  logic              granted;
  logic              err;
  logic [WAKE_W-1:0] cls;
  logic [ID_W-1:0]   tgt;
  logic              idx_ok;
  logic              id_ok;
  logic              kind_ok;
  logic              blocked;
  logic              take_bad;
  logic [2:0]        kind_mask;
  logic              rd_full;

  // last reader gone: hand the lock to a waiting writer
  function automatic void wake_writer(inout entry_t e, inout logic [WAKE_W-1:0] c,
                                      inout logic [ID_W-1:0] t);
    if (e.readers == '0 && e.waiters[WAIT_WRITE]) begin
      e.waiters[WAIT_WRITE] = 1'b0;
      if (e.intent) begin
        c = WAKE_WRITER;
        t = e.owner;
      end
    end
  endfunction

  // drop one intent level, free the intent lock at the outermost level
  function automatic void release_intent(inout entry_t e, inout logic [WAKE_W-1:0] c);
    if (e.recursion != '0) begin
      e.recursion = e.recursion - REC_W'(1);
    end else begin
      e.intent = 1'b0;
      e.owner  = '0;
      if (e.waiters[WAIT_INTENT]) begin
        e.waiters[WAIT_INTENT] = 1'b0;
        c = WAKE_INTENT;
      end
    end
  endfunction

  assign idx_ok  = 32'(req.lock_index) < NUM_LOCKS;
  assign id_ok   = 32'(req.requester_id) < NUM_REQUESTERS;
  assign rd_full = cur.readers >= READER_CAP;

  // per-mode blocking and take checks
  always_comb begin
    kind_ok   = 1'b1;
    blocked   = 1'b0;
    take_bad  = 1'b0;
    kind_mask = 3'b000;
    unique case (req.lock_kind)
      KIND_READ: begin
        blocked   = cur.seq[0];
        take_bad  = rd_full;
        kind_mask = 3'b001;
      end
      KIND_INTENT: begin
        blocked   = cur.intent;
        kind_mask = 3'b010;
      end
      KIND_WRITE: begin
        blocked   = cur.readers != '0;
        take_bad  = cur.seq[0] || !cur.intent || (cur.owner != req.requester_id);
        kind_mask = 3'b100;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  // read-modify-write of one entry
  always_comb begin
    n       = cur;
    granted = 1'b0;
    err     = 1'b0;
    cls     = WAKE_NONE;
    tgt     = '0;
    if (!idx_ok || !id_ok) begin
      err = 1'b1;
    end else if (!kind_ok && req.func != FN_UPGRADE && req.func != FN_DOWNGRADE) begin
      err = 1'b1;
    end else begin
      unique case (req.func)
        FN_TRYLOCK, FN_RELOCK, FN_WAIT: begin
          if (take_bad) begin
            err = 1'b1;
          end else if (blocked || (req.func == FN_RELOCK && cur.seq != req.seq_tag)) begin
            if (req.func == FN_WAIT && blocked) begin
              n.waiters = cur.waiters | kind_mask;
            end
          end else begin
            granted = 1'b1;
            unique case (req.lock_kind)
              KIND_READ:   n.readers = cur.readers + RDR_W'(1);
              KIND_INTENT: begin
                n.intent = 1'b1;
                n.owner  = req.requester_id;
              end
              default:     n.seq = cur.seq + SEQ_W'(1);
            endcase
          end
        end
        FN_UNLOCK: begin
          unique case (req.lock_kind)
            KIND_READ: begin
              if (cur.readers == '0) begin
                err = 1'b1;
              end else begin
                n.readers = cur.readers - RDR_W'(1);
                wake_writer(n, cls, tgt);
              end
            end
            KIND_INTENT: begin
              if (!cur.intent) begin
                err = 1'b1;
              end else begin
                release_intent(n, cls);
              end
            end
            default: begin
              if (!cur.seq[0]) begin
                err = 1'b1;
              end else begin
                n.seq = cur.seq + SEQ_W'(1);
                if (cur.waiters[WAIT_READ]) begin
                  n.waiters[WAIT_READ] = 1'b0;
                  cls = WAKE_READERS;
                end
              end
            end
          endcase
        end
        FN_UPGRADE: begin
          if (cur.readers == '0) begin
            err = 1'b1;
          end else if (!cur.intent) begin
            n.readers = cur.readers - RDR_W'(1);
            n.intent  = 1'b1;
            n.owner   = req.requester_id;
            granted   = 1'b1;
            wake_writer(n, cls, tgt);
          end
        end
        FN_DOWNGRADE: begin
          if (!cur.intent || rd_full) begin
            err = 1'b1;
          end else begin
            n.readers = cur.readers + RDR_W'(1);
            release_intent(n, cls);
          end
        end
        FN_INCREMENT: begin
          unique case (req.lock_kind)
            KIND_READ: begin
              if (rd_full) begin
                err = 1'b1;
              end else begin
                n.readers = cur.readers + RDR_W'(1);
              end
            end
            KIND_INTENT: begin
              if (!cur.intent || cur.recursion >= RECURSE_CAP) begin
                err = 1'b1;
              end else begin
                n.recursion = cur.recursion + REC_W'(1);
              end
            end
            default: begin
              err = 1'b1;
            end
          endcase
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
  end

  // result and write-back control
  assign nxt                   = n;
  assign upd.we                = !err;
  assign upd.res.granted       = granted;
  assign upd.res.request_error = err;
  assign upd.res.wake_class    = cls;
  assign upd.res.wake_target   = tgt;
  assign upd.res.seq_now       = idx_ok ? n.seq : '0;
  assign upd.res.readers_now   = idx_ok ? n.readers : '0;
  assign upd.res.intent_now    = idx_ok ? n.intent : 1'b0;

endmodule

### sv/shared_intent_exclusive_lock_table_top.sv
// Lock table with read, intent and write modes, one entry per lock, held in a
// single synchronous table memory. Each request is one read-modify-write of
// its entry: the entry is read at the edge that accepts the transaction, and
// in the execute state it is updated, written back and the result is
// registered; a stalled previous result holds that state. A new transaction
// is taken only in the idle state, after the write-back of the last one. The
// result register frees the request side: a new transaction is taken while
// the previous result still waits. After reset the table is cleared one entry
// a cycle, all NUM_LOCKS (64 by default), with no request taken meanwhile.
module shared_intent_exclusive_lock_table_top
  import siel_pkg::*;
#(
  parameter int NUM_LOCKS = DEF_NUM_LOCKS
) (
  input logic          clk,
  input logic          rst,
  siel_chan_if.sink    req,
  siel_chan_if.source  rsp
);

  localparam int ADDR_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_last;
  req_t              req_q;
  rsp_t              rsp_q;
  logic              rsp_valid;
  logic              accept;
  logic              finish;
  entry_t            rd_entry;
  entry_t            new_entry;
  upd_t              upd;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign finish    = (state == ST_EXEC) && (!rsp_valid || rsp.ready);
  assign clr_last  = (clr_addr == ADDR_W'(NUM_LOCKS - 1));

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // hold the accepted request for the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req.data;
    end
  end

  // table write port: clearing pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(req_q.lock_index);
    mem_wdata = new_entry;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (finish) begin
      mem_we = upd.we;
    end
  end

  siel_mem #(
    .DEPTH  (NUM_LOCKS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (ADDR_W'(req.data.lock_index)),
    .rdata (rd_entry)
  );

  siel_update #(
    .NUM_LOCKS (NUM_LOCKS)
  ) u_update (
    .req (req_q),
    .cur (rd_entry),
    .nxt (new_entry),
    .upd (upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_q <= upd.res;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

endmodule

### sv/siel_checker.sv
module siel_checker
  import siel_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // a stalled result holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // every request finishes its read-modify-write before the next one is taken
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken during update cycle");

  // a flagged request is neither granted nor wakes anyone
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.request_error |->
      !rsp_data.granted && rsp_data.wake_class == WAKE_NONE)
    else $error("error result granted or woke a waiter");

  // a wake target is named only for a writer wake
  a_target_writer: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.wake_class != WAKE_WRITER |-> rsp_data.wake_target == '0)
    else $error("wake target without writer wake");

endmodule

bind shared_intent_exclusive_lock_table_top siel_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
